>>> design/mtw_pkg.sv
// mtw_pkg: shared types, constants and mode codes for the multi-task watchdog
// no dependencies; imported by mtw_step, multi_task_watchdog_core, mtw_checker and the bench
package mtw_pkg;

	// client and register sizing
	localparam int MAX_CLIENTS   = 8;
	localparam int ID_W          = 3;
	localparam int CNT_IDS_W     = 4;
	localparam int TICK_W        = 24;
	localparam int CFG_IDX_W     = 1;
	localparam int CFG_DATA_W    = 24;
	localparam int IN_DATA_W     = 8;
	localparam int OUT_DATA_W    = 24;

	localparam logic [TICK_W-1:0] TIMEOUT_RESET = TICK_W'(96);

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_REQUIRE_ENROLL = 1'd1;

	// item modes
	typedef enum logic [2:0] {
		MODE_ALLOC     = 3'd0,
		MODE_TRACK_ON  = 3'd1,
		MODE_TRACK_OFF = 3'd2,
		MODE_CHECK_IN  = 3'd3,
		MODE_KICK      = 3'd4,
		MODE_ENABLE    = 3'd5,
		MODE_DISABLE   = 3'd6,
		MODE_TICK      = 3'd7
	} mtw_mode_t;

	// watchdog state
	typedef struct packed {
		logic [CNT_IDS_W-1:0]   ids_given;
		logic [MAX_CLIENTS-1:0] tracked;
		logic [MAX_CLIENTS-1:0] pending;
		logic                   timer_on;
		logic [TICK_W-1:0]      tick_count;
		logic                   expired;
	} mtw_state_t;

	// one result item
	typedef struct packed {
		logic [MAX_CLIENTS-1:0] pending_mask;
		logic [MAX_CLIENTS-1:0] tracked_mask;
		logic                   sleep_safe;
		logic                   running;
		logic                   expired;
		logic                   kicked;
		logic                   alloc_failed;
		logic [ID_W-1:0]        given_id;
	} mtw_result_t;

endpackage

>>> design/multi_task_watchdog_core.sv
// multi_task_watchdog_core: top level of the multi-client watchdog
// depends on mtw_pkg and mtw_step
//
// Usage:
//   s_* channel takes one item per transfer: mode (allocate, track on/off,
//   check in, kick, enable, disable, tick) and a client id.
//   m_* channel returns exactly one result per item: allocated id, allocate
//   failure, kick flag, sticky expiry, running, sleep-safe and both masks.
//   cfg_we/cfg_index/cfg_wdata write timeout_ticks (index 0) and
//   require_enrollment (index 1); write only while no item is in flight.
// Timing:
//   an item is held in the input register, then its result is loaded
//   into the output register, which drives m_tvalid and m_tdata.
//   The state update is combinational, so one item per cycle is
//   sustained while m_tready stays high.
// Stall and reset:
//   when m_tready is low the result holds and the input register holds one
//   more item; s_tready drops only once both are full.
//   arst_n clears all masks, the counter, the expiry flag, both channels and
//   sets timeout_ticks to 96 and require_enrollment to 0.
module multi_task_watchdog_core
	import mtw_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	// input item, lowest bit up: mode[2:0], client_id[5:3], zero pad[7:6]
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// result item, lowest bit up: given_id[2:0], alloc_failed[3], kicked[4],
	// expired[5], running[6], sleep_safe[7], tracked_mask[15:8], pending_mask[23:16]
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,
	// configuration write port
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	logic [TICK_W-1:0]  timeout_q;
	logic               enroll_q;
	mtw_state_t         state_q;
	mtw_state_t         state_nxt;
	mtw_result_t        res_nxt;

	logic               valid_s1;
	mtw_mode_t          mode_s1;
	logic [ID_W-1:0]    id_s1;

	logic               out_valid_q;
	mtw_result_t        out_q;

	logic               advance;

	// result register free or being drained
	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RESET;
			enroll_q  <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TIMEOUT_TICKS:  timeout_q <= cfg_wdata[TICK_W-1:0];
				REG_REQUIRE_ENROLL: enroll_q  <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			mode_s1 <= mtw_mode_t'(s_tdata[2:0]);
			id_s1   <= s_tdata[5:3];
		end
	end

	// item logic
	mtw_step u_step (
		.cur            (state_q),
		.mode           (mode_s1),
		.client_id      (id_s1),
		.timeout_ticks  (timeout_q),
		.require_enroll (enroll_q),
		.nxt            (state_nxt),
		.res            (res_nxt)
	);

	// watchdog state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			out_q <= res_nxt;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;

endmodule

>>> design/mtw_step.sv
// mtw_step: next-state and result logic for one watchdog item
// depends on mtw_pkg
module mtw_step
	import mtw_pkg::*;
(
	input  mtw_state_t        cur,
	input  mtw_mode_t         mode,
	input  logic [ID_W-1:0]   client_id,
	input  logic [TICK_W-1:0] timeout_ticks,
	input  logic              require_enroll,
	output mtw_state_t        nxt,
	output mtw_result_t       res
);

	logic [MAX_CLIENTS-1:0] bit_sel;
	logic                   valid_id;

	assign bit_sel  = MAX_CLIENTS'(1) << client_id;
	assign valid_id = {1'b0, client_id} < cur.ids_given;

	// state update for the item
	always_comb begin
		mtw_state_t             s;
		logic                   kick;
		logic                   failed;
		logic [ID_W-1:0]        given;
		logic [MAX_CLIENTS-1:0] pend;
		logic                   do_check_in;
		logic [TICK_W-1:0]      cnt_inc;

		s           = cur;
		kick        = 1'b0;
		failed      = 1'b0;
		given       = '0;
		do_check_in = 1'b0;
		cnt_inc     = cur.tick_count;

		unique case (mode)
			MODE_ALLOC: begin
				if (cur.ids_given < CNT_IDS_W'(MAX_CLIENTS)) begin
					given       = cur.ids_given[ID_W-1:0];
					s.ids_given = cur.ids_given + 1'b1;
				end else begin
					failed = 1'b1;
				end
			end
			MODE_TRACK_ON: begin
				if (valid_id) begin
					// first enrolled client starts a stopped timer
					if (require_enroll && cur.tracked == '0 && !cur.timer_on) begin
						s.timer_on   = 1'b1;
						s.tick_count = '0;
						kick         = 1'b1;
					end
					s.tracked   = cur.tracked | bit_sel;
					do_check_in = 1'b1;
				end
			end
			MODE_TRACK_OFF: begin
				if (valid_id) begin
					s.tracked = cur.tracked & ~bit_sel;
					// last client leaving stops the timer
					if (require_enroll && s.tracked == '0)
						s.timer_on = 1'b0;
					do_check_in = 1'b1;
				end
			end
			MODE_CHECK_IN: begin
				do_check_in = valid_id;
			end
			MODE_KICK: begin
				s.tick_count = '0;
				kick         = 1'b1;
			end
			MODE_ENABLE: begin
				if (!cur.timer_on) begin
					s.timer_on   = 1'b1;
					s.tick_count = '0;
					kick         = 1'b1;
				end
			end
			MODE_DISABLE: begin
				s.timer_on = 1'b0;
			end
			MODE_TICK: begin
				if (cur.timer_on) begin
					if (cur.tick_count < timeout_ticks)
						cnt_inc = cur.tick_count + 1'b1;
					s.tick_count = cnt_inc;
					if (cnt_inc >= timeout_ticks)
						s.expired = 1'b1;
				end
			end
			default: ;
		endcase

		// check-in: clear own pending bit; when no tracked client is still pending, clear the counter and reload pending
		pend = cur.pending & ~bit_sel;
		if (do_check_in) begin
			if ((pend & s.tracked) == '0) begin
				s.tick_count = '0;
				kick         = 1'b1;
				s.pending    = s.tracked;
			end else begin
				s.pending = pend;
			end
		end

		nxt              = s;
		res.given_id     = given;
		res.alloc_failed = failed;
		res.kicked       = kick;
		res.expired      = s.expired;
		res.running      = s.timer_on;
		res.sleep_safe   = (s.tracked == '0);
		res.tracked_mask = s.tracked;
		res.pending_mask = s.pending;
	end

endmodule

>>> design/mtw_checker.sv
// mtw_checker: port-level assertions for multi_task_watchdog_core, with bind
// depends on mtw_pkg and multi_task_watchdog_core
module mtw_checker
	import mtw_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_tvalid,
	input logic                  s_tready,
	input logic [IN_DATA_W-1:0]  s_tdata,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [OUT_DATA_W-1:0] m_tdata,
	input logic                  cfg_we,
	input logic [CFG_IDX_W-1:0]  cfg_index,
	input logic [CFG_DATA_W-1:0] cfg_wdata
);

	// stalled result stays offered
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	// expiry never clears once shown
	a_expired_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[5] |=> !m_tvalid || m_tdata[5])
		else $error("expiry flag cleared");

	// sleep-safe agrees with the tracked mask
	a_sleep_safe: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[7] == (m_tdata[15:8] == '0))
		else $error("sleep_safe inconsistent with tracked mask");

	// pending clients are always tracked clients
	a_pending_subset: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[23:16] & ~m_tdata[15:8]) == '0)
		else $error("pending client not tracked");

	// failed allocate hands out no id
	a_alloc_fail_id: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[3] |-> m_tdata[2:0] == '0)
		else $error("id given on failed allocate");

endmodule

bind multi_task_watchdog_core mtw_checker u_mtw_checker (.*);

>>> dv/tb_multi_task_watchdog_core.sv
// tb_multi_task_watchdog_core: self-checking bench for the multi-client watchdog core
// stream driver and monitor with a watchdog predictor and an in-order result scoreboard
// depends on mtw_pkg and multi_task_watchdog_core
module tb_multi_task_watchdog_core;
	import mtw_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	// items waiting to be offered and results waiting to arrive
	logic [IN_DATA_W-1:0] pending_items[$];
	mtw_result_t          expected_results[$];

	logic in_xfer = 1'b0;
	bit   idle_on = 1'b1;
	bit   long_stall_req = 1'b0;
	int   send_gap = 0;
	int   stall_left = 0;
	int   mismatches = 0;

	// predicted watchdog state and register copies
	logic [CNT_IDS_W-1:0]   wd_ids = '0;
	logic [MAX_CLIENTS-1:0] wd_tracked = '0;
	logic [MAX_CLIENTS-1:0] wd_pending = '0;
	logic                   wd_timer_on = 1'b0;
	logic [TICK_W-1:0]      wd_ticks = '0;
	logic                   wd_expired = 1'b0;
	logic [TICK_W-1:0]      timeout_cfg = TIMEOUT_RESET;
	logic                   enroll_cfg = 1'b0;

	multi_task_watchdog_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always #4 clk = ~clk;

	// apply one item to the predicted state and build its result
	function automatic mtw_result_t watchdog_step(mtw_mode_t mode, logic [ID_W-1:0] id);
		mtw_result_t r;
		logic        known_id;
		logic        do_checkin;
		r = '0;
		known_id = {1'b0, id} < wd_ids;
		do_checkin = 1'b0;
		case (mode)
			MODE_ALLOC: begin
				if (wd_ids < MAX_CLIENTS) begin
					r.given_id = wd_ids[ID_W-1:0];
					wd_ids = wd_ids + 1'b1;
				end else begin
					r.alloc_failed = 1'b1;
				end
			end
			MODE_TRACK_ON: begin
				if (known_id) begin
					// first enrolled client starts a stopped timer
					if (enroll_cfg && wd_tracked == '0 && !wd_timer_on) begin
						wd_timer_on = 1'b1;
						wd_ticks = '0;
						r.kicked = 1'b1;
					end
					wd_tracked[id] = 1'b1;
					do_checkin = 1'b1;
				end
			end
			MODE_TRACK_OFF: begin
				if (known_id) begin
					wd_tracked[id] = 1'b0;
					if (enroll_cfg && wd_tracked == '0)
						wd_timer_on = 1'b0;
					do_checkin = 1'b1;
				end
			end
			MODE_CHECK_IN: do_checkin = known_id;
			MODE_KICK: begin
				wd_ticks = '0;
				r.kicked = 1'b1;
			end
			MODE_ENABLE: begin
				if (!wd_timer_on) begin
					wd_timer_on = 1'b1;
					wd_ticks = '0;
					r.kicked = 1'b1;
				end
			end
			MODE_DISABLE: wd_timer_on = 1'b0;
			default: begin
				if (wd_timer_on) begin
					if (wd_ticks < timeout_cfg)
						wd_ticks = wd_ticks + 1'b1;
					if (wd_ticks >= timeout_cfg)
						wd_expired = 1'b1;
				end
			end
		endcase
		// check-in: clear own pending bit; once all tracked clients are in, clear counter and reload pending
		if (do_checkin) begin
			wd_pending[id] = 1'b0;
			if ((wd_pending & wd_tracked) == '0) begin
				wd_ticks = '0;
				r.kicked = 1'b1;
				wd_pending = wd_tracked;
			end
		end
		r.expired      = wd_expired;
		r.running      = wd_timer_on;
		r.sleep_safe   = (wd_tracked == '0);
		r.tracked_mask = wd_tracked;
		r.pending_mask = wd_pending;
		return r;
	endfunction

	// monitor: score result transfers, predict on input transfers
	always @(posedge clk) begin : monitor
		mtw_result_t got;
		mtw_result_t want;
		in_xfer <= s_tvalid && s_tready;
		if (arst_n && m_tvalid && m_tready) begin
			got = mtw_result_t'(m_tdata);
			if (expected_results.size() == 0) begin
				if (mismatches < 10)
					$display("unexpected result transfer: %06h", m_tdata);
				mismatches++;
			end else begin
				want = expected_results.pop_front();
				if (got.given_id !== want.given_id || got.alloc_failed !== want.alloc_failed ||
						got.kicked !== want.kicked || got.expired !== want.expired ||
						got.running !== want.running || got.sleep_safe !== want.sleep_safe ||
						got.tracked_mask !== want.tracked_mask ||
						got.pending_mask !== want.pending_mask) begin
					if (mismatches < 10) begin
						$display("result mismatch at %0t", $realtime);
						$display("  expected id=%0d fail=%0b kick=%0b exp=%0b run=%0b safe=%0b trk=%02h pnd=%02h",
							want.given_id, want.alloc_failed, want.kicked, want.expired,
							want.running, want.sleep_safe, want.tracked_mask, want.pending_mask);
						$display("  actual   id=%0d fail=%0b kick=%0b exp=%0b run=%0b safe=%0b trk=%02h pnd=%02h",
							got.given_id, got.alloc_failed, got.kicked, got.expired,
							got.running, got.sleep_safe, got.tracked_mask, got.pending_mask);
					end
					mismatches++;
				end
			end
		end
		if (arst_n && s_tvalid && s_tready)
			expected_results.push_back(watchdog_step(mtw_mode_t'(s_tdata[2:0]), s_tdata[5:3]));
	end

	// driver: offer queued items, with a random gap after some transfers while idle_on is set
	always @(negedge clk) begin
		if (!s_tvalid || in_xfer) begin
			if (send_gap > 0) begin
				send_gap--;
				s_tvalid <= 1'b0;
			end else if (pending_items.size() > 0) begin
				s_tdata <= pending_items.pop_front();
				s_tvalid <= 1'b1;
				if (idle_on && $urandom_range(0, 4) == 0)
					send_gap = $urandom_range(1, 6);
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// result sink: random stall bursts and one long hold-off on request
	always @(negedge clk) begin
		if (long_stall_req) begin
			long_stall_req = 1'b0;
			stall_left = 64;
			m_tready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 4) == 0) begin
			stall_left = $urandom_range(0, 5);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	task automatic push_item(input mtw_mode_t mode, input logic [ID_W-1:0] id);
		pending_items.push_back({2'b00, id, mode});
	endtask

	// wait until every queued item is sent and every result has arrived
	task automatic wait_idle();
		do begin
			@(posedge clk);
			#1;
		end while (pending_items.size() != 0 || s_tvalid || expected_results.size() != 0);
	endtask

	// register write while idle, mirrored into the predictor
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		if (idx == REG_TIMEOUT_TICKS)
			timeout_cfg = value;
		else
			enroll_cfg = value[0];
		@(negedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		#1;
	endtask

	// one random phase under a given register setting
	task automatic random_phase(input logic [TICK_W-1:0] timeout, input logic enroll,
			input int count, input bit long_stall);
		int        pick;
		mtw_mode_t mode;
		write_reg(REG_TIMEOUT_TICKS, timeout);
		write_reg(REG_REQUIRE_ENROLL, {{(CFG_DATA_W-1){1'b0}}, enroll});
		if (long_stall)
			long_stall_req = 1'b1;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 35)
				mode = MODE_CHECK_IN;
			else if (pick < 65)
				mode = MODE_TICK;
			else if (pick < 75)
				mode = MODE_TRACK_ON;
			else if (pick < 83)
				mode = MODE_TRACK_OFF;
			else if (pick < 88)
				mode = MODE_KICK;
			else if (pick < 93)
				mode = MODE_ENABLE;
			else if (pick < 97)
				mode = MODE_DISABLE;
			else
				mode = MODE_ALLOC;
			push_item(mode, ID_W'($urandom_range(0, MAX_CLIENTS - 1)));
		end
		wait_idle();
	endtask

	// stimulus sequence
	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);
		#1;

		// ids not yet handed out, tick and enable edge cases
		push_item(MODE_TRACK_ON, 3'd0);
		push_item(MODE_CHECK_IN, 3'd3);
		push_item(MODE_TICK, 3'd0);
		push_item(MODE_ENABLE, 3'd0);
		push_item(MODE_ENABLE, 3'd7);
		// hand out all ids, the last request finds none left
		repeat (MAX_CLIENTS + 1)
			push_item(MODE_ALLOC, 3'd0);
		// track, check in until all are in, then drop tracking
		push_item(MODE_TRACK_ON, 3'd7);
		push_item(MODE_TRACK_ON, 3'd0);
		push_item(MODE_CHECK_IN, 3'd7);
		push_item(MODE_CHECK_IN, 3'd0);
		push_item(MODE_TRACK_OFF, 3'd7);
		push_item(MODE_TRACK_OFF, 3'd0);
		// kick and tick while stopped
		push_item(MODE_DISABLE, 3'd0);
		push_item(MODE_KICK, 3'd0);
		push_item(MODE_TICK, 3'd0);
		wait_idle();
		// enrollment starts and stops the timer
		write_reg(REG_REQUIRE_ENROLL, 24'd1);
		push_item(MODE_TRACK_ON, 3'd3);
		push_item(MODE_TRACK_OFF, 3'd3);
		wait_idle();

		random_phase(TIMEOUT_RESET, 1'b0, 90, 1'b0);
		random_phase({TICK_W{1'b1}}, 1'b1, 90, 1'b1);
		random_phase(24'd12, 1'b0, 90, 1'b0);

		// timeout lowered below the running count, then zero
		write_reg(REG_TIMEOUT_TICKS, 24'd10);
		write_reg(REG_REQUIRE_ENROLL, 24'd0);
		push_item(MODE_ENABLE, 3'd0);
		push_item(MODE_KICK, 3'd0);
		repeat (5)
			push_item(MODE_TICK, 3'd0);
		wait_idle();
		write_reg(REG_TIMEOUT_TICKS, 24'd2);
		push_item(MODE_TICK, 3'd0);
		push_item(MODE_KICK, 3'd0);
		wait_idle();
		write_reg(REG_TIMEOUT_TICKS, 24'd0);
		push_item(MODE_TICK, 3'd0);
		wait_idle();

		random_phase(24'd1, 1'b1, 90, 1'b0);
		idle_on = 1'b0;
		random_phase(24'd0, 1'b0, 90, 1'b0);

		repeat (8) @(posedge clk);
		if (mismatches == 0 && expected_results.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// run limit
	initial begin
		#(2_000_000);
		$display("Mismatches found");
		$finish;
	end

endmodule

>>> files.f
design/mtw_pkg.sv
design/mtw_step.sv
design/multi_task_watchdog_core.sv
design/mtw_checker.sv
dv/tb_multi_task_watchdog_core.sv
